@@ hw/rtl/evtf_pkg.sv @@
// ----------------------------------------------------------------------------
// evtf_pkg
// Shared constants and helpers for the encoder velocity trimmed-mean filter.
// ----------------------------------------------------------------------------
package evtf_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE = 1'd1;

  // Register widths and reset values
  localparam int PERIOD_W = 8;
  localparam int SCALE_W  = 24;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd1;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd2978909;

  // Data path widths
  localparam int DATA_W    = 32;             // counts, rpm, filter value
  localparam int MUL_B_W   = SCALE_W + 1;    // signed second operand
  localparam int PROD_W    = DATA_W + MUL_B_W;
  localparam int ACC_W     = 41;             // 133*y + 123*mean
  localparam int SUM_W     = 35;             // sum of up to six samples

  // Low-pass coefficients (Q8)
  localparam int COEF_FEEDBACK = 133;
  localparam int COEF_INPUT    = 123;

  // Default window length
  localparam int WINDOW_DEFAULT = 10;

  // Clamp a wide signed value into the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/encoder_velocity_trimmed_filter.sv @@
// ----------------------------------------------------------------------------
// encoder_velocity_trimmed_filter
// Encoder speed estimate: sampled count delta scaled to rpm, trimmed mean
// over a window of samples, then a first-order low-pass filter.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//  input   | in_valid in_ready encoder_count           | in
//  output  | out_valid out_ready sample_velocity       | out
//          |   filtered_velocity filter_updated        |
//
// A tick that takes no sample is absorbed without leaving the idle state. A
// sample tick passes through S_MUL, S_RPM and S_EMIT to the output register
// (one shared multiplier pass). A sample that completes the window adds a
// rank scan on one comparator, division by reciprocal multiplication on the
// shared multiplier and the filter states.
// Reset is synchronous, active high. The output register holds a result
// while out_ready is low; a new request is taken only once the previous
// result has moved to that register.
module encoder_velocity_trimmed_filter #(
  parameter int WINDOW = evtf_pkg::WINDOW_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [evtf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [evtf_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [evtf_pkg::DATA_W-1:0]    encoder_count,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [evtf_pkg::DATA_W-1:0]    sample_velocity,
  output logic signed [evtf_pkg::DATA_W-1:0]    filtered_velocity,
  output logic                                  filter_updated
);

  import evtf_pkg::*;

  localparam int IW          = $clog2(WINDOW);
  localparam int FW          = $clog2(WINDOW + 1);
  localparam int KEEP_COUNT  = (WINDOW < 6) ? WINDOW : 6;
  localparam int KEEP_START  = (WINDOW - KEEP_COUNT) / 2;
  localparam int REM_W       = $clog2(KEEP_COUNT);
  // division by the keep count: high part, then remainder joined to low part
  localparam int DIV_SPLIT   = 18;
  localparam int HI_W        = SUM_W - DIV_SPLIT;
  localparam int QH_W        = DATA_W - DIV_SPLIT;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + KEEP_COUNT - 1) / KEEP_COUNT;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_RPM, S_KEY, S_KEYL, S_SCAN, S_ACC,
    S_DIVLD, S_DH, S_DQH, S_DL, S_MEAN, S_F1, S_F2, S_F3, S_EMIT
  } state_t;

  state_t                      state;

  // configuration registers
  logic [PERIOD_W-1:0]         sample_period;
  logic [SCALE_W-1:0]          velocity_scale;

  // architectural state
  logic [PERIOD_W-1:0]         tick_count;
  logic [DATA_W-1:0]           previous_count;
  logic [FW-1:0]               fill_count;
  logic signed [DATA_W-1:0]    smoothed_velocity;

  // working registers
  logic signed [DATA_W-1:0]    rpm_reg;
  logic                        updated;
  logic signed [DATA_W-1:0]    key;
  logic [IW-1:0]               i;
  logic [FW-1:0]               j;
  logic [IW-1:0]               jd;
  logic [FW-1:0]               rank;
  logic signed [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]            div_num;
  logic [QH_W-1:0]             div_qh;
  logic                        div_neg;
  logic signed [DATA_W-1:0]    mean_reg;
  logic signed [ACC_W-1:0]     acc;

  // shared multiplier
  logic signed [DATA_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;

  // sample memory
  logic signed [DATA_W-1:0]    sample_mem [WINDOW];
  logic [IW-1:0]               rd_addr;
  logic signed [DATA_W-1:0]    rd_data;
  logic                        mem_we;

  // combinational helpers
  logic                        in_fire;
  logic                        sample_tick;
  logic [DATA_W-1:0]           delta;
  logic signed [DATA_W-1:0]    rpm_val;
  logic                        rank_hit;
  logic                        in_keep;
  logic [SUM_W-1:0]            div_mag;
  logic [HI_W-1:0]             qh_val;
  logic [HI_W-1:0]             rh_val;
  logic [DATA_W-1:0]           div_quot;
  logic signed [ACC_W-1:0]     filt_sum;
  logic signed [ACC_W-9:0]     filt_sh;
  logic signed [DATA_W-1:0]    filt_val;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // sample timing and count delta (wraps at 32 bits)
  assign sample_tick = (tick_count == sample_period);
  assign delta       = encoder_count - previous_count;

  // rpm: arithmetic shift by eight, then saturate
  assign rpm_val = sat32({{(64 - PROD_W + 8){prod[PROD_W-1]}}, prod[PROD_W-1:8]});

  // rank of the key: smaller values, plus equal values at lower index
  assign rank_hit = (rd_data < key) || ((rd_data == key) && (jd < i));
  assign in_keep  = (rank >= FW'(KEEP_START)) && (rank < FW'(KEEP_START + KEEP_COUNT));

  // magnitude for floor division: negative sums biased up by count - 1
  assign div_mag = sum[SUM_W-1] ? (SUM_W'(-sum) + SUM_W'(KEEP_COUNT - 1)) : SUM_W'(sum);

  // reciprocal quotient of the high part, its remainder, and the full quotient
  assign qh_val   = prod[RECIP_SHIFT +: HI_W];
  assign rh_val   = div_num[SUM_W-1:DIV_SPLIT] - qh_val * HI_W'(KEEP_COUNT);
  assign div_quot = {div_qh, prod[RECIP_SHIFT +: DIV_SPLIT]};

  // filter sum, floor shift, clamp
  assign filt_sum = acc + prod[ACC_W-1:0];
  assign filt_sh  = filt_sum[ACC_W-1:8];
  assign filt_val = sat32({{(64 - ACC_W + 8){filt_sh[ACC_W-9]}}, filt_sh});

  // memory read address
  always_comb begin
    unique case (state)
      S_KEY:   rd_addr = i;
      S_SCAN:  rd_addr = (j < FW'(WINDOW)) ? j[IW-1:0] : '0;
      default: rd_addr = '0;
    endcase
  end

  assign mem_we = (state == S_RPM);

  // sample memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[fill_count[IW-1:0]] <= rpm_val;
    end
    rd_data <= sample_mem[rd_addr];
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sample_period     <= PERIOD_RESET;
      velocity_scale    <= SCALE_RESET;
      tick_count        <= '0;
      previous_count    <= '0;
      fill_count        <= '0;
      smoothed_velocity <= '0;
      out_valid         <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SAMPLE_PERIOD:  sample_period  <= cfg_data[PERIOD_W-1:0];
          CFG_VELOCITY_SCALE: velocity_scale <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      // output register drain; a reload in S_EMIT takes its place
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (sample_tick) begin
              tick_count     <= PERIOD_W'(1);
              previous_count <= encoder_count;
              mul_a          <= delta;
              mul_b          <= {1'b0, velocity_scale};
              state          <= S_MUL;
            end else begin
              tick_count <= tick_count + PERIOD_W'(1);
            end
          end
        end

        S_MUL: state <= S_RPM;

        S_RPM: begin
          rpm_reg <= rpm_val;
          if (fill_count == FW'(WINDOW - 1)) begin
            fill_count <= '0;
            i          <= '0;
            sum        <= '0;
            state      <= S_KEY;
          end else begin
            fill_count <= fill_count + FW'(1);
            updated    <= 1'b0;
            state      <= S_EMIT;
          end
        end

        S_KEY: state <= S_KEYL;

        S_KEYL: begin
          key   <= rd_data;
          j     <= FW'(1);
          jd    <= '0;
          rank  <= '0;
          state <= S_SCAN;
        end

        // one compare per cycle against the held key
        S_SCAN: begin
          if (rank_hit) begin
            rank <= rank + FW'(1);
          end
          j  <= j + FW'(1);
          jd <= jd + IW'(1);
          if (jd == IW'(WINDOW - 1)) begin
            state <= S_ACC;
          end
        end

        S_ACC: begin
          if (in_keep) begin
            sum <= sum + SUM_W'(key);
          end
          i <= i + IW'(1);
          if (i == IW'(WINDOW - 1)) begin
            state <= S_DIVLD;
          end else begin
            state <= S_KEY;
          end
        end

        // high part of the magnitude times the reciprocal
        S_DIVLD: begin
          div_num <= div_mag;
          div_neg <= sum[SUM_W-1];
          mul_a   <= DATA_W'(div_mag[SUM_W-1:DIV_SPLIT]);
          mul_b   <= MUL_B_W'(RECIP);
          state   <= S_DH;
        end

        S_DH: state <= S_DQH;

        // remainder of the high part joined to the low part
        S_DQH: begin
          div_qh <= qh_val[QH_W-1:0];
          mul_a  <= DATA_W'({rh_val[REM_W-1:0], div_num[DIV_SPLIT-1:0]});
          state  <= S_DL;
        end

        S_DL: state <= S_MEAN;

        S_MEAN: begin
          mean_reg <= div_neg ? -div_quot : div_quot;
          mul_a    <= smoothed_velocity;
          mul_b    <= MUL_B_W'(COEF_FEEDBACK);
          state    <= S_F1;
        end

        S_F1: begin
          mul_a <= mean_reg;
          mul_b <= MUL_B_W'(COEF_INPUT);
          state <= S_F2;
        end

        S_F2: begin
          acc   <= prod[ACC_W-1:0];
          state <= S_F3;
        end

        S_F3: begin
          smoothed_velocity <= filt_val;
          updated           <= 1'b1;
          state             <= S_EMIT;
        end

        // hand the result to the output register
        S_EMIT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            sample_velocity   <= rpm_reg;
            filtered_velocity <= smoothed_velocity;
            filter_updated    <= updated;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_encoder_velocity_trimmed_filter.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_velocity_trimmed_filter
// Self-checking bench for the encoder velocity filter. Encoder counts are
// pushed through the request channel and a scoreboard predicts each sample
// (rpm, trimmed-mean low-pass value, update flag). Every result is then
// checked in order. The run starts with a short directed burst at reset
// settings. After that come phases of motor-like count streams with random
// noise, one register setting per phase, with random gaps on both sides except in calm phases.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [evtf_pkg::DATA_W-1:0] sample_rpm;
  logic signed [evtf_pkg::DATA_W-1:0] filtered_rpm;
  logic                               updated;
} speed_result_t;

// Predicts the speed results and holds them until the block delivers them
class speed_scoreboard #(int WIN = evtf_pkg::WINDOW_DEFAULT);
  logic [evtf_pkg::PERIOD_W-1:0]      period;
  logic [evtf_pkg::SCALE_W-1:0]       scale;
  logic [7:0]                         tick_count;
  logic [evtf_pkg::DATA_W-1:0]        last_count;
  int                                 window [WIN];
  int                                 filled;
  logic signed [evtf_pkg::DATA_W-1:0] smoothed;
  speed_result_t                      pending_speeds [$];
  int                                 faults;

  function new();
    period     = evtf_pkg::PERIOD_RESET;
    scale      = evtf_pkg::SCALE_RESET;
    tick_count = '0;
    last_count = '0;
    filled     = 0;
    smoothed   = '0;
    faults     = 0;
  endfunction

  function int outstanding();
    return pending_speeds.size();
  endfunction

  function void fault(string msg);
    faults++;
    if (faults <= 10) begin
      $display("mismatch %0d: %s", faults, msg);
    end
  endfunction

  function void set_register(logic [evtf_pkg::CFG_IDX_W-1:0] idx,
                             logic [evtf_pkg::CFG_DATA_W-1:0] data);
    if (idx == evtf_pkg::CFG_SAMPLE_PERIOD) begin
      period = data[evtf_pkg::PERIOD_W-1:0];
    end else if (idx == evtf_pkg::CFG_VELOCITY_SCALE) begin
      scale = data[evtf_pkg::SCALE_W-1:0];
    end
  endfunction

  // Saturate into signed 32 bits
  function logic signed [31:0] clamp_q8(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // One encoder tick: maybe a sample, maybe a completed window
  function void note_tick(logic [31:0] count);
    logic signed [31:0] delta;
    longint             product, sum, mean, acc;
    int                 sorted [WIN];
    int                 key, j, keep, first;
    speed_result_t      r;
    if (tick_count == period) begin
      delta        = count - last_count;
      product      = longint'(delta) * longint'({40'd0, scale});
      r.sample_rpm = clamp_q8(product >>> 8);
      r.updated    = 1'b0;
      last_count   = count;
      if (filled >= WIN) begin
        filled = 0;
      end
      window[filled] = r.sample_rpm;
      filled++;
      if (filled >= WIN) begin
        // insertion sort, then mean of the kept middle
        sorted = window;
        for (int i = 1; i < WIN; i++) begin
          key = sorted[i];
          j   = i - 1;
          while (j >= 0 && sorted[j] > key) begin
            sorted[j+1] = sorted[j];
            j--;
          end
          sorted[j+1] = key;
        end
        keep  = (WIN < 6) ? WIN : 6;
        first = (WIN - keep) / 2;
        sum   = 0;
        for (int k = 0; k < keep; k++) begin
          sum += sorted[first+k];
        end
        mean = sum / keep;
        if ((sum % keep) != 0 && sum < 0) begin
          mean--;
        end
        acc       = 133 * longint'(smoothed) + 123 * mean;
        smoothed  = clamp_q8(acc >>> 8);
        filled    = 0;
        r.updated = 1'b1;
      end
      r.filtered_rpm = smoothed;
      pending_speeds.push_back(r);
      tick_count = '0;
    end
    tick_count = tick_count + 8'd1;
  endfunction

  function void check_speed(logic signed [31:0] rpm, logic signed [31:0] filt, logic upd);
    speed_result_t want;
    if (pending_speeds.size() == 0) begin
      fault($sformatf("unexpected result rpm=%0d filtered=%0d updated=%0b", rpm, filt, upd));
      return;
    end
    want = pending_speeds.pop_front();
    if (rpm !== want.sample_rpm) begin
      fault($sformatf("sample_velocity exp %0d got %0d", want.sample_rpm, rpm));
    end
    if (filt !== want.filtered_rpm) begin
      fault($sformatf("filtered_velocity exp %0d got %0d", want.filtered_rpm, filt));
    end
    if (upd !== want.updated) begin
      fault($sformatf("filter_updated exp %0b got %0b", want.updated, upd));
    end
  endfunction
endclass

module tb_encoder_velocity_trimmed_filter;
  import evtf_pkg::*;

  localparam int SETTLE_CYCLES = 256;   // longer than a window completion
  localparam int STALL_LIMIT   = 2000;
  localparam int TICK_TARGET   = 1050;

  // extremes, wraps and sign flips of the count delta
  localparam logic [31:0] DIRECTED_COUNTS [24] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h7FFF_FFFF, 32'h0000_0064, 32'h0000_0190, 32'h0000_0032,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_000C, 32'h0000_000C,
    32'hFFFF_FF00, 32'h0000_0100, 32'h0000_03E8, 32'h0000_0BB8,
    32'h0000_0B54, 32'h0000_0B55, 32'h4000_0000, 32'hC000_0000
  };

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [DATA_W-1:0]  encoder_count;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [DATA_W-1:0]  sample_velocity;
  logic signed [DATA_W-1:0]  filtered_velocity;
  logic                      filter_updated;

  speed_scoreboard speeds;
  bit              no_gaps;
  int              idle_cycles = 0;
  int              sent;
  logic [31:0]     motor_count;
  int              motor_step;

  encoder_velocity_trimmed_filter dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .encoder_count     (encoder_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sample_velocity   (sample_velocity),
    .filtered_velocity (filtered_velocity),
    .filter_updated    (filter_updated)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Monitor: register writes, requests, results and the stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        speeds.set_register(cfg_index, cfg_data);
      end
      if (out_valid && out_ready) begin
        speeds.check_speed(sample_velocity, filtered_velocity, filter_updated);
      end
      if (in_valid && in_ready) begin
        speeds.note_tick(encoder_count);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: random back-pressure before each result unless no_gaps is set
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // New motor speed for a phase
  function automatic void pick_speed();
    case ($urandom_range(0, 3))
      0:       motor_step = $urandom_range(0, 30) - 15;
      1:       motor_step = $urandom_range(0, 4000) - 2000;
      2:       motor_step = $urandom_range(0, 1 << 21) - (1 << 20);
      default: motor_step = $urandom;
    endcase
  endfunction

  // Steady counting with jitter; now and then a glitch count
  function automatic logic [31:0] next_count();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom;
    end
    motor_count = motor_count + motor_step + $urandom_range(0, 6) - 3;
    return motor_count;
  endfunction

  task automatic send_tick(logic [31:0] count);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    encoder_count <= count;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold requests until every result is in and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (speeds.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [PERIOD_W-1:0] period, logic [SCALE_W-1:0] scale,
                           int ticks, bit calm);
    drain();
    write_register(CFG_SAMPLE_PERIOD, {(CFG_DATA_W-PERIOD_W)'($urandom), period});
    write_register(CFG_VELOCITY_SCALE, scale);
    no_gaps = calm;
    pick_speed();
    repeat (ticks) send_tick(next_count());
  endtask

  initial begin
    speeds        = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SAMPLE_PERIOD;
    cfg_data      = '0;
    in_valid      = 1'b0;
    encoder_count = '0;
    no_gaps       = 1'b0;
    sent          = 0;
    motor_count   = '0;
    motor_step    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: period 1, default scale
    foreach (DIRECTED_COUNTS[i]) begin
      send_tick(DIRECTED_COUNTS[i]);
    end

    // register extremes; period 0 is set once the tick counter has moved on
    run_phase(8'd1, 24'hFF_FFFF, 80, 1'b0);
    run_phase(8'd255, SCALE_W'($urandom_range(0, 24'hFF_FFFF)), 300, 1'b1);
    run_phase(8'd0, SCALE_W'($urandom_range(0, 24'hFF_FFFF)), 230, 1'b0);
    run_phase(8'd2, 24'd0, 40, 1'b0);

    // random settings, mostly short periods so windows complete often
    while (sent < TICK_TARGET) begin
      run_phase(PERIOD_W'(($urandom_range(0, 4) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 6)),
                SCALE_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                     : $urandom_range(1000000, 6000000)),
                $urandom_range(30, 80), $urandom_range(0, 3) == 0);
    end

    drain();
    if (speeds.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
